[rtl/pcpa_pkg.sv]
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types and constants for the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

    localparam int NUM_CPUS_DEF   = 8;
    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic [31:0] FREE_BASE_RST  = 32'h8000_0000;
    localparam logic [31:0] FREE_LIMIT_RST = 32'h8800_0000;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_ADDR = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_CHK,
        S_FREE_PUSH,
        S_ALLOC_PICK,
        S_ALLOC_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  cpu_id;
        logic [31:0] page_addr;
    } t_req;

    typedef struct packed {
        logic [31:0] alloc_addr;
        t_status     status;
    } t_rsp;

endpackage

[rtl/per_cpu_page_free_list_allocator.sv]
// A free word steps through S_FREE_CHK, S_FREE_PUSH and S_DONE, an allocate
// through S_ALLOC_PICK, S_ALLOC_POP and S_DONE (no S_ALLOC_POP when every list
// is empty). One request is in flight at a time: a new word is taken only once
// S_DONE has loaded the output register; S_DONE holds off while a stalled
// result sits there. That register lets the next word be accepted while a
// result waits. Reset empties every CPU list and restores free_base/free_limit.
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// LIFO page free list per CPU: head registers plus a next-link memory
// indexed by page. Allocate takes from its own CPU list, else steals from the
// lowest non-empty CPU list.
module per_cpu_page_free_list_allocator
    import pcpa_pkg::*;
#(
    parameter int NUM_CPUS   = NUM_CPUS_DEF,
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_req                 i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_rsp                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int PS = $clog2(PAGE_BYTES);
    localparam int DW = 32 - PS;
    localparam int PW = $clog2(NUM_PAGES);
    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    t_state r_state, n_state;

    logic [31:0]         r_free_base;
    logic [31:0]         r_free_limit;
    logic [NUM_CPUS-1:0] r_head_ok;
    logic [PW-1:0]       r_head_idx [NUM_CPUS];
    logic [PW:0]         r_link_mem [NUM_PAGES];
    logic [PW:0]         r_rd_data;

    logic [CW-1:0] r_cpu;
    logic [31:0]   r_page_addr;
    logic          r_good;
    logic [DW-1:0] r_diff;
    logic [31:0]   r_res_addr;
    t_status       r_res_status;
    logic          r_out_valid;
    t_rsp          r_out;

    logic          in_accept;
    logic          out_load;
    logic          push_ok;
    logic          any_ok;
    logic [CW-1:0] pick;
    logic [4:0]    cpu_mod;
    logic [DW-1:0] pop_page_num;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Fold the CPU number into range
    always_comb begin
        cpu_mod = {2'b00, i_in_data.cpu_id};
        for (int k = 0; k < 7; k++) begin
            if (cpu_mod >= 5'(NUM_CPUS)) begin
                cpu_mod = cpu_mod - 5'(NUM_CPUS);
            end
        end
    end

    // Own list first, else the lowest non-empty one
    always_comb begin
        pick = r_cpu;
        for (int i = NUM_CPUS - 1; i >= 0; i--) begin
            if (r_head_ok[i]) begin
                pick = CW'(i);
            end
        end
        if (r_head_ok[r_cpu]) begin
            pick = r_cpu;
        end
    end

    assign any_ok       = |r_head_ok;
    assign push_ok      = r_good && ({{PS{1'b0}}, r_diff} < 32'(NUM_PAGES));
    assign pop_page_num = r_free_base[31:PS] + DW'(r_head_idx[r_cpu]);

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_data.req_type == REQ_FREE) ? S_FREE_CHK : S_ALLOC_PICK;
                end
            end
            S_FREE_CHK:   n_state = S_FREE_PUSH;
            S_FREE_PUSH:  n_state = S_DONE;
            S_ALLOC_PICK: n_state = any_ok ? S_ALLOC_POP : S_DONE;
            S_ALLOC_POP:  n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head_ok    <= '0;
            r_out_valid  <= 1'b0;
            r_free_base  <= FREE_BASE_RST;
            r_free_limit <= FREE_LIMIT_RST;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_FREE_PUSH && push_ok) begin
                r_head_ok[r_cpu] <= 1'b1;
            end
            if (r_state == S_ALLOC_POP) begin
                r_head_ok[r_cpu] <= r_rd_data[PW];
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FREE_BASE:  r_free_base  <= i_cfg_data;
                    REG_FREE_LIMIT: r_free_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cpu       <= CW'(cpu_mod);
            r_page_addr <= i_in_data.page_addr;
        end
        if (r_state == S_FREE_CHK) begin
            r_good <= (r_page_addr[PS-1:0] == '0) && (r_page_addr >= r_free_base)
                      && (r_page_addr < r_free_limit);
            r_diff <= r_page_addr[31:PS] - r_free_base[31:PS];
        end
        if (r_state == S_FREE_PUSH) begin
            if (push_ok) begin
                r_head_idx[r_cpu] <= PW'(r_diff);
            end
            r_res_addr   <= '0;
            r_res_status <= push_ok ? ST_OK : ST_BAD_ADDR;
        end
        if (r_state == S_ALLOC_PICK) begin
            r_cpu <= pick;
            if (!any_ok) begin
                r_res_addr   <= '0;
                r_res_status <= ST_EMPTY;
            end
        end
        if (r_state == S_ALLOC_POP) begin
            r_head_idx[r_cpu] <= r_rd_data[PW-1:0];
            r_res_addr        <= {pop_page_num, {PS{1'b0}}};
            r_res_status      <= ST_OK;
        end
        if (out_load) begin
            r_out.alloc_addr <= r_res_addr;
            r_out.status     <= r_res_status;
        end
    end

    // Link memory: push writes the old head under the new page, pop reads it
    always_ff @(posedge i_clk) begin
        if (r_state == S_FREE_PUSH && push_ok) begin
            r_link_mem[PW'(r_diff)] <= {r_head_ok[r_cpu], r_head_idx[r_cpu]};
        end
        r_rd_data <= r_link_mem[r_head_idx[pick]];
    end

endmodule

[rtl/pcpa_chk.sv]
// ----------------------------------------------------------------------------
// pcpa_chk
// Port-level checks for the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
module pcpa_chk
    import pcpa_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_req i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_rsp o_out_data
);

    localparam int PS = $clog2(PAGE_BYTES);

    // One request at a time: the word just taken blocks the next
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a request is in flight");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.alloc_addr == 32'd0))
        else $error("failed request returned a nonzero address");

    a_addr_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.alloc_addr[PS-1:0] == '0))
        else $error("allocated address not page aligned");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output word changed while stalled");

endmodule

bind per_cpu_page_free_list_allocator pcpa_chk #(
    .PAGE_BYTES(PAGE_BYTES)
) u_pcpa_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

[tb/tb_per_cpu_page_free_list_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_cpu_page_free_list_allocator
// Self-checking bench for the per-CPU page allocator. A queue of request words
// feeds a bursty driver. A local model of the CPU lists and link memory works
// out every response, and a monitor compares it field by field against the
// block's output. The block is run under several base/limit settings.
// ----------------------------------------------------------------------------
module tb_per_cpu_page_free_list_allocator;
    import pcpa_pkg::*;

    localparam int          NCPU        = NUM_CPUS_DEF;
    localparam int          NPAGES      = NUM_PAGES_DEF;
    localparam logic [31:0] PG          = PAGE_BYTES_DEF;
    localparam int          QUIET_LIMIT = 4000;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_style;
    typedef enum {BAD_MISALIGNED, BAD_BELOW, BAD_ABOVE, BAD_BEYOND} t_bad_kind;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_req                 in_word   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_rsp                 o_out_data;
    logic                 o_cfg_ready;

    // local copy of the allocator state
    logic [31:0] base_reg  = FREE_BASE_RST;
    logic [31:0] limit_reg = FREE_LIMIT_RST;
    int unsigned head_page [NCPU];
    bit          head_live [NCPU];
    int unsigned link_page [NPAGES];
    bit          link_live [NPAGES];

    t_req page_req_q [$];
    t_rsp page_rsp_q [$];
    int   req_count    = 0;
    int   errors       = 0;
    int   quiet_cycles = 0;
    int   fresh_idx    = 0;
    int   send_gap     = 0;
    int   send_burst   = 1;
    int   stall_span   = 0;
    int   stall_tick   = 0;
    t_stall_style stall_style = STALL_NONE;

    per_cpu_page_free_list_allocator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit take_page(input int c, output logic [31:0] addr);
        int unsigned idx;
        addr = '0;
        if (!head_live[c])
            return 1'b0;
        idx = head_page[c];
        head_page[c] = link_page[idx];
        head_live[c] = link_live[idx];
        addr = (base_reg / PG + idx) * PG;
        return 1'b1;
    endfunction

    function automatic t_rsp serve_page_request(input t_req rq);
        t_rsp        r;
        logic [31:0] idx;
        int          c;
        bit          got;
        c = rq.cpu_id % NCPU;
        r.alloc_addr = '0;
        r.status = ST_OK;
        if (rq.req_type == REQ_FREE) begin
            idx = rq.page_addr / PG - base_reg / PG;
            if (rq.page_addr % PG != 0 || rq.page_addr < base_reg ||
                rq.page_addr >= limit_reg || idx >= NPAGES) begin
                r.status = ST_BAD_ADDR;
            end else begin
                link_page[idx] = head_page[c];
                link_live[idx] = head_live[c];
                head_page[c] = idx;
                head_live[c] = 1'b1;
            end
        end else begin
            got = take_page(c, r.alloc_addr);
            // steal from the lowest-numbered other CPU
            for (int i = 0; i < NCPU && !got; i++)
                if (i != c)
                    got = take_page(i, r.alloc_addr);
            if (!got) begin
                r.alloc_addr = '0;
                r.status = ST_EMPTY;
            end
        end
        return r;
    endfunction

    task automatic push_req(input logic kind, input int cpu, input logic [31:0] pa);
        t_req rq;
        rq.req_type = kind;
        rq.cpu_id = 3'(cpu);
        rq.page_addr = pa;
        page_req_q.push_back(rq);
        req_count++;
    endtask

    function automatic logic [31:0] good_addr(input int unsigned idx);
        return (base_reg / PG + idx) * PG;
    endfunction

    function automatic int unsigned pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            fresh_idx = (fresh_idx + $urandom_range(1, 97)) % NPAGES;
        else if (r >= 93)
            return $urandom_range(0, NPAGES - 1);
        // otherwise free the latest page again
        return fresh_idx;
    endfunction

    function automatic logic [31:0] bad_addr();
        logic [31:0] pa;
        t_bad_kind   kind;
        kind = t_bad_kind'($urandom_range(0, 3));
        pa = $urandom;
        case (kind)
            BAD_BELOW: begin
                if (base_reg >= PG)
                    pa = $urandom_range(0, base_reg / PG - 1) * PG;
            end
            BAD_ABOVE: begin
                pa = (limit_reg / PG + (limit_reg % PG != 0) + $urandom_range(0, 15)) * PG;
            end
            BAD_BEYOND: begin
                pa = (base_reg / PG + NPAGES + $urandom_range(0, 1000)) * PG;
            end
            default: ;
        endcase
        if (kind == BAD_MISALIGNED && pa % PG == 0)
            pa[0] = 1'b1;
        return pa;
    endfunction

    task automatic add_mixed(input int n);
        int stop;
        int pick;
        int k;
        stop = req_count + n;
        while (req_count < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // fill a few lists, then drain them past empty
                k = $urandom_range(1, 10);
                repeat (k)
                    push_req(REQ_FREE, $urandom_range(0, 7), good_addr(pick_index()));
                repeat (k + $urandom_range(0, 3))
                    push_req(REQ_ALLOC, $urandom_range(0, 7), $urandom);
            end else if (pick < 48) begin
                push_req(REQ_ALLOC, $urandom_range(0, 7), $urandom);
            end else if (pick < 90) begin
                push_req(REQ_FREE, $urandom_range(0, 7), good_addr(pick_index()));
            end else begin
                push_req(REQ_FREE, $urandom_range(0, 7), bad_addr());
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_FREE_BASE)
            base_reg = val;
        else
            limit_reg = val;
    endtask

    task automatic wait_drained();
        while (page_req_q.size() != 0 || in_valid || page_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input logic [31:0] base, input logic [31:0] limit, input int n);
        write_reg(REG_FREE_BASE, base);
        write_reg(REG_FREE_LIMIT, limit);
        add_mixed(n);
        wait_drained();
    endtask

    // request driver: bursts of words with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                page_rsp_q.push_back(serve_page_request(in_word));
            if (!in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (page_req_q.size() > 0) begin
                    in_word  <= page_req_q.pop_front();
                    in_valid <= 1'b1;
                    send_burst--;
                    if (send_burst <= 0) begin
                        send_burst = $urandom_range(1, 32);
                        send_gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (page_rsp_q.size() == 0) begin
                $error("unexpected response word: alloc_addr %h status %0d",
                       o_out_data.alloc_addr, o_out_data.status);
                errors++;
            end else begin
                want = page_rsp_q.pop_front();
                if (o_out_data.alloc_addr !== want.alloc_addr) begin
                    $error("alloc_addr: expected %h, got %h",
                           want.alloc_addr, o_out_data.alloc_addr);
                    errors++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, switching to a random style after each random span
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_style = t_stall_style'($urandom_range(0, 3));
                stall_span = $urandom_range(20, 300);
            end else begin
                stall_span--;
            end
            stall_tick++;
            case (stall_style)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= (stall_tick % 7) < 3;
            endcase
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under the reset base and limit
        push_req(REQ_ALLOC, 0, 32'h0000_0000);
        push_req(REQ_FREE,  0, 32'h8000_0000);
        push_req(REQ_FREE,  7, 32'h87FF_F000);
        push_req(REQ_FREE,  3, 32'h8800_0000);
        push_req(REQ_FREE,  1, 32'h7FFF_F000);
        push_req(REQ_FREE,  2, 32'h8000_0001);
        push_req(REQ_FREE,  2, 32'h8000_0800);
        push_req(REQ_FREE,  6, 32'hFFFF_FFFF);
        push_req(REQ_FREE,  6, 32'h0000_0000);
        push_req(REQ_ALLOC, 7, 32'hFFFF_FFFF);
        push_req(REQ_ALLOC, 7, 32'h0000_0000);
        push_req(REQ_ALLOC, 2, 32'h0000_0000);
        push_req(REQ_FREE,  5, 32'h8000_1000);
        push_req(REQ_FREE,  5, 32'h8000_2000);
        push_req(REQ_FREE,  2, 32'h8000_3000);
        push_req(REQ_ALLOC, 5, 32'h0000_0000);
        push_req(REQ_ALLOC, 1, 32'h0000_0000);
        push_req(REQ_ALLOC, 1, 32'h0000_0000);
        // double free makes a looping list; a free onto an empty CPU ends it
        push_req(REQ_FREE,  4, 32'h8000_4000);
        push_req(REQ_FREE,  4, 32'h8000_4000);
        push_req(REQ_ALLOC, 4, 32'h0000_0000);
        push_req(REQ_ALLOC, 4, 32'h0000_0000);
        push_req(REQ_FREE,  6, 32'h8000_4000);
        push_req(REQ_ALLOC, 4, 32'h0000_0000);
        push_req(REQ_ALLOC, 6, 32'h0000_0000);
        push_req(REQ_ALLOC, 3, 32'h0000_0000);
        add_mixed(450);
        wait_drained();

        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 200);
        run_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 60);
        run_phase(32'h1234_5ABC, 32'h1A34_5000, 200);
        run_phase(32'h0000_0000, 32'h0000_0000, 60);
        run_phase(FREE_BASE_RST, FREE_LIMIT_RST, 150);

        repeat (20) @(posedge clk);
        if (errors == 0 && page_rsp_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
